@@ rtl/prsint_pkg.sv @@
package prsint_pkg;

    localparam int VALUE_WIDTH_DEF = 64;

    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CH_LOWER_B = 8'h62;
    localparam logic [7:0] CH_LOWER_O = 8'h6F;
    localparam logic [7:0] CASE_OFFSET = 8'h20;
    localparam logic [7:0] LETTER_BASE = 8'd10;

    typedef enum logic [3:0] {
        PH_START  = 4'b0001,
        PH_SIGNED = 4'b0010,
        PH_ZERO   = 4'b0100,
        PH_DIGITS = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_HEX = 2'd1,
        RADIX_BIN = 2'd2,
        RADIX_OCT = 2'd3
    } radix_t;

    typedef struct packed {
        phase_t phase;
        radix_t radix;
        logic   neg;
        logic   failed;
    } ctrl_t;

    typedef struct packed {
        radix_t base;
        logic   ok;
    } status_t;

    function automatic logic [4:0] radix_value(radix_t r);
        logic [4:0] v;
        case (r)
            RADIX_DEC: v = 5'd10;
            RADIX_HEX: v = 5'd16;
            RADIX_BIN: v = 5'd2;
            RADIX_OCT: v = 5'd8;
            default:   v = 5'd10;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/prsint_step.sv @@
module prsint_step #(
    parameter int VALUE_WIDTH = prsint_pkg::VALUE_WIDTH_DEF
) (
    input  prsint_pkg::ctrl_t        cur,
    input  logic [VALUE_WIDTH-1:0]   acc,
    input  logic [VALUE_WIDTH-1:0]   nacc,
    input  logic [7:0]               char_in,
    input  logic                     last_in,
    input  logic                     signed_en,
    output prsint_pkg::ctrl_t        nxt,
    output logic [VALUE_WIDTH-1:0]   acc_next,
    output logic [VALUE_WIDTH-1:0]   nacc_next,
    output logic [VALUE_WIDTH-1:0]   res_value,
    output prsint_pkg::status_t      res_status
);

    logic [7:0]             lc;
    logic                   is_dig;
    logic                   is_let;
    logic [7:0]             dig_raw;
    logic [5:0]             dig;
    logic                   digit_ok;
    logic                   do_digit;
    logic [VALUE_WIDTH-1:0] dig_ext;
    logic [VALUE_WIDTH-1:0] acc_mul;
    logic [VALUE_WIDTH-1:0] nacc_mul;
    prsint_pkg::ctrl_t      upd;
    logic [VALUE_WIDTH-1:0] acc_upd;
    logic [VALUE_WIDTH-1:0] nacc_upd;

    always_comb begin
        lc = (char_in inside {[prsint_pkg::CH_UPPER_A:prsint_pkg::CH_UPPER_Z]})
             ? char_in + prsint_pkg::CASE_OFFSET : char_in;
        is_dig  = lc inside {[prsint_pkg::CH_ZERO:prsint_pkg::CH_NINE]};
        is_let  = lc inside {[prsint_pkg::CH_LOWER_A:prsint_pkg::CH_LOWER_Z]};
        dig_raw = is_dig ? lc - prsint_pkg::CH_ZERO
                         : lc - prsint_pkg::CH_LOWER_A + prsint_pkg::LETTER_BASE;
        dig     = dig_raw[5:0];
        digit_ok = (is_dig || is_let)
                   && (dig < {1'b0, prsint_pkg::radix_value(cur.radix)});
        dig_ext = VALUE_WIDTH'(dig);
    end

    // negated accumulator is tracked alongside so the result needs no extra adder
    always_comb begin
        case (cur.radix)
            prsint_pkg::RADIX_DEC: begin
                acc_mul  = (acc << 3) + (acc << 1);
                nacc_mul = (nacc << 3) + (nacc << 1);
            end
            prsint_pkg::RADIX_HEX: begin
                acc_mul  = acc << 4;
                nacc_mul = nacc << 4;
            end
            prsint_pkg::RADIX_BIN: begin
                acc_mul  = acc << 1;
                nacc_mul = nacc << 1;
            end
            prsint_pkg::RADIX_OCT: begin
                acc_mul  = acc << 3;
                nacc_mul = nacc << 3;
            end
            default: begin
                acc_mul  = acc;
                nacc_mul = nacc;
            end
        endcase
    end

    always_comb begin
        upd      = cur;
        acc_upd  = acc;
        nacc_upd = nacc;
        do_digit = 1'b0;
        if (!cur.failed) begin
            case (cur.phase)
                prsint_pkg::PH_START: begin
                    if (signed_en && char_in == prsint_pkg::CH_MINUS) begin
                        upd.neg   = 1'b1;
                        upd.phase = prsint_pkg::PH_SIGNED;
                    end else if (char_in == prsint_pkg::CH_ZERO) begin
                        upd.phase = prsint_pkg::PH_ZERO;
                    end else begin
                        do_digit  = 1'b1;
                        upd.phase = prsint_pkg::PH_DIGITS;
                    end
                end
                prsint_pkg::PH_SIGNED: begin
                    if (char_in == prsint_pkg::CH_ZERO) begin
                        upd.phase = prsint_pkg::PH_ZERO;
                    end else begin
                        do_digit  = 1'b1;
                        upd.phase = prsint_pkg::PH_DIGITS;
                    end
                end
                prsint_pkg::PH_ZERO: begin
                    if (lc == prsint_pkg::CH_LOWER_X) begin
                        upd.radix = prsint_pkg::RADIX_HEX;
                    end else if (lc == prsint_pkg::CH_LOWER_B) begin
                        upd.radix = prsint_pkg::RADIX_BIN;
                    end else if (lc == prsint_pkg::CH_LOWER_O) begin
                        upd.radix = prsint_pkg::RADIX_OCT;
                    end else begin
                        do_digit = 1'b1;
                    end
                    upd.phase = prsint_pkg::PH_DIGITS;
                end
                prsint_pkg::PH_DIGITS: begin
                    do_digit = 1'b1;
                end
                default: begin
                    upd.phase = prsint_pkg::PH_START;
                end
            endcase
        end
        if (do_digit) begin
            if (digit_ok) begin
                acc_upd  = acc_mul + dig_ext;
                nacc_upd = nacc_mul - dig_ext;
            end else begin
                upd.failed = 1'b1;
            end
        end
    end

    always_comb begin
        if (upd.failed) begin
            res_value = '0;
        end else if (upd.neg) begin
            res_value = nacc_upd;
        end else begin
            res_value = acc_upd;
        end
        res_status.ok   = !upd.failed;
        res_status.base = upd.radix;

        if (last_in) begin
            nxt.phase  = prsint_pkg::PH_START;
            nxt.radix  = prsint_pkg::RADIX_DEC;
            nxt.neg    = 1'b0;
            nxt.failed = 1'b0;
            acc_next   = '0;
            nacc_next  = '0;
        end else begin
            nxt       = upd;
            acc_next  = acc_upd;
            nacc_next = nacc_upd;
        end
    end

endmodule

@@ rtl/prsint_outbuf.sv @@
module prsint_outbuf #(
    parameter int VALUE_WIDTH = prsint_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  logic [VALUE_WIDTH-1:0] value_in,
    input  prsint_pkg::status_t    status_in,
    output logic                   out_free,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [VALUE_WIDTH-1:0] value_out,
    output prsint_pkg::status_t    status_out
);

    logic                   valid_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    prsint_pkg::status_t    status_reg;

    assign out_free   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign value_out  = value_reg;
    assign status_out = status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            value_reg  <= value_in;
            status_reg <= status_in;
        end
    end

endmodule

@@ rtl/prefixed_integer_parser.sv @@
// Prefixed integer parser.
// Input stream: one ASCII character per word in s_tdata[7:0], s_tlast on the
// final character of a number string. Optional '-' (when signed mode is set),
// then an optional 0x / 0b / 0o prefix (either case), then digits.
// Result stream: one word per string, on its last character. m_tdata holds
// the value (two's complement if negative, wrapped to VALUE_WIDTH bits),
// m_tuser[0] is parse_ok and m_tuser[2:1] the base code
// (0 decimal, 1 hex, 2 binary, 3 octal). A failed parse gives value 0.
// Config channel: cfg_data[0] is signed_enable, always ready, reset value 1.
// Throughput: one character per cycle, unless a final character waits for the
// result register. Each character passes an input register and combinational
// digit/accumulate logic; the result word is then loaded into the result register.
// When m_tready is low and a result waits, non-final characters keep flowing;
// a final character holds in the input register until the result register
// frees up, which then backpressures s_tready.
// Reset (aresetn low, synchronous) empties both registers, clears the string
// state and sets signed_enable to 1.
module prefixed_integer_parser #(
    parameter int VALUE_WIDTH = prsint_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,   // [7:0] character
    input  logic                                 s_tlast,   // last_char
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((VALUE_WIDTH+7)/8)*8-1:0]     m_tdata,   // value
    output logic [2:0]                           m_tuser,   // [0] parse_ok, [2:1] base_code
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic                                 cfg_data   // signed_enable
);

    localparam int TDATA_W = ((VALUE_WIDTH + 7) / 8) * 8;

    logic                   in_valid_reg;
    logic [7:0]             in_char_reg;
    logic                   in_last_reg;
    logic                   signed_en_reg;
    prsint_pkg::ctrl_t      ctrl_reg;
    prsint_pkg::ctrl_t      ctrl_next;
    logic [VALUE_WIDTH-1:0] acc_reg;
    logic [VALUE_WIDTH-1:0] acc_next;
    logic [VALUE_WIDTH-1:0] nacc_reg;
    logic [VALUE_WIDTH-1:0] nacc_next;
    logic [VALUE_WIDTH-1:0] res_value;
    prsint_pkg::status_t    res_status;
    logic                   out_free;
    logic                   advance;
    logic [VALUE_WIDTH-1:0] out_value;
    prsint_pkg::status_t    out_status;

    assign advance   = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            signed_en_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            signed_en_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg.phase  <= prsint_pkg::PH_START;
            ctrl_reg.radix  <= prsint_pkg::RADIX_DEC;
            ctrl_reg.neg    <= 1'b0;
            ctrl_reg.failed <= 1'b0;
            acc_reg         <= '0;
            nacc_reg        <= '0;
        end else if (advance) begin
            ctrl_reg <= ctrl_next;
            acc_reg  <= acc_next;
            nacc_reg <= nacc_next;
        end
    end

    prsint_step #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_step (
        .cur        (ctrl_reg),
        .acc        (acc_reg),
        .nacc       (nacc_reg),
        .char_in    (in_char_reg),
        .last_in    (in_last_reg),
        .signed_en  (signed_en_reg),
        .nxt        (ctrl_next),
        .acc_next   (acc_next),
        .nacc_next  (nacc_next),
        .res_value  (res_value),
        .res_status (res_status)
    );

    prsint_outbuf #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_outbuf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (advance && in_last_reg),
        .value_in   (res_value),
        .status_in  (res_status),
        .out_free   (out_free),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .value_out  (out_value),
        .status_out (out_status)
    );

    assign m_tdata = TDATA_W'(out_value);
    assign m_tuser = {out_status.base, out_status.ok};

`ifndef SYNTH
    // a failed parse always reports zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("failed parse with nonzero value");

    // string state is back at its start after a final character
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_last_reg) |=>
            (ctrl_reg.phase == prsint_pkg::PH_START && acc_reg == '0 && nacc_reg == '0))
        else $error("string state not cleared after last word");

    // a prefix radix only ever appears once digits have begun
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl_reg.radix != prsint_pkg::RADIX_DEC) |-> (ctrl_reg.phase == prsint_pkg::PH_DIGITS))
        else $error("radix set outside digit phase");

    // accumulator and its negation stay consistent
    assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |-> ((acc_reg + nacc_reg) == '0))
        else $error("negated accumulator out of step");
`endif

endmodule

@@ tb/sv/parse_checker.sv @@
`timescale 1ns / 1ps

module parse_checker #(
    parameter int VALUE_WIDTH = prsint_pkg::VALUE_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] character
    input  logic                             s_tlast,   // last_char
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0] m_tdata,   // value
    input  logic [2:0]                       m_tuser,   // [0] parse_ok, [2:1] base_code
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic                             cfg_data,  // signed_enable
    output int                               mismatches,
    output int                               awaiting
);

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic                   ok;
        prsint_pkg::radix_t     base;
    } parse_result_t;

    parse_result_t          expected_numbers[$];
    int                     fail_count = 0;
    int                     pending = 0;

    logic                   signed_en;
    prsint_pkg::phase_t     phase;
    prsint_pkg::radix_t     radix;
    logic                   neg_seen;
    logic                   failed;
    logic [VALUE_WIDTH-1:0] acc;

    assign mismatches = fail_count;
    assign awaiting   = pending;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c >= prsint_pkg::CH_UPPER_A && c <= prsint_pkg::CH_UPPER_Z)
               ? c + prsint_pkg::CASE_OFFSET : c;
    endfunction

    task automatic clear_string();
        phase    = prsint_pkg::PH_START;
        radix    = prsint_pkg::RADIX_DEC;
        neg_seen = 1'b0;
        failed   = 1'b0;
        acc      = '0;
    endtask

    task automatic accumulate_digit(input logic [7:0] raw);
        logic [7:0]  c;
        int unsigned base;
        int unsigned d;
        c = fold_case(raw);
        case (radix)
            prsint_pkg::RADIX_HEX: base = 16;
            prsint_pkg::RADIX_BIN: base = 2;
            prsint_pkg::RADIX_OCT: base = 8;
            default:               base = 10;
        endcase
        if (c >= prsint_pkg::CH_ZERO && c <= prsint_pkg::CH_NINE) begin
            d = 32'(c - prsint_pkg::CH_ZERO);
        end else if (c >= prsint_pkg::CH_LOWER_A && c <= prsint_pkg::CH_LOWER_Z) begin
            d = 32'(c - prsint_pkg::CH_LOWER_A + prsint_pkg::LETTER_BASE);
        end else begin
            d = 99;
        end
        if (d >= base) begin
            failed = 1'b1;
        end else begin
            acc = acc * VALUE_WIDTH'(base) + VALUE_WIDTH'(d);
        end
    endtask

    task automatic start_body(input logic [7:0] c);
        if (c == prsint_pkg::CH_ZERO) begin
            phase = prsint_pkg::PH_ZERO;
        end else begin
            accumulate_digit(c);
            phase = prsint_pkg::PH_DIGITS;
        end
    endtask

    task automatic absorb_char(input logic [7:0] c, input logic lst);
        logic [7:0]    lc;
        parse_result_t r;
        if (!failed) begin
            case (phase)
                prsint_pkg::PH_START: begin
                    if (signed_en && c == prsint_pkg::CH_MINUS) begin
                        neg_seen = 1'b1;
                        phase    = prsint_pkg::PH_SIGNED;
                    end else begin
                        start_body(c);
                    end
                end
                prsint_pkg::PH_SIGNED: begin
                    start_body(c);
                end
                prsint_pkg::PH_ZERO: begin
                    lc = fold_case(c);
                    if (lc == prsint_pkg::CH_LOWER_X) radix = prsint_pkg::RADIX_HEX;
                    else if (lc == prsint_pkg::CH_LOWER_B) radix = prsint_pkg::RADIX_BIN;
                    else if (lc == prsint_pkg::CH_LOWER_O) radix = prsint_pkg::RADIX_OCT;
                    else accumulate_digit(c);
                    phase = prsint_pkg::PH_DIGITS;
                end
                default: begin
                    accumulate_digit(c);
                end
            endcase
        end
        if (lst) begin
            // sign is fixed by what was taken at the head of the string
            r.value = failed ? '0 : (neg_seen ? -acc : acc);
            r.ok    = !failed;
            r.base  = radix;
            expected_numbers.push_back(r);
            clear_string();
        end
    endtask

    always @(posedge aclk) begin
        parse_result_t want;
        if (!aresetn) begin
            signed_en = 1'b1;
            clear_string();
            expected_numbers.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_numbers.size() == 0) begin
                    $error("result word with nothing expected: value %h user %b",
                           m_tdata, m_tuser);
                    fail_count++;
                end else begin
                    want = expected_numbers.pop_front();
                    if (m_tdata[VALUE_WIDTH-1:0] !== want.value) begin
                        $error("value: expected %h, got %h", want.value,
                               m_tdata[VALUE_WIDTH-1:0]);
                        fail_count++;
                    end
                    if (m_tuser[0] !== want.ok) begin
                        $error("parse_ok: expected %b, got %b", want.ok, m_tuser[0]);
                        fail_count++;
                    end
                    if (m_tuser[2:1] !== want.base) begin
                        $error("base_code: expected %0d, got %0d", want.base, m_tuser[2:1]);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                signed_en = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                absorb_char(s_tdata, s_tlast);
            end
        end
        pending = expected_numbers.size();
    end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int VW            = prsint_pkg::VALUE_WIDTH_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_CHARS   = 550;

    // boundary neighbors of the digit and letter ranges, plus stray symbols
    localparam logic [7:0] ODD_CHARS [16] = '{
        8'h00, 8'h2B, 8'h2D, 8'h2E, 8'h2F, 8'h3A, 8'h40, 8'h5B,
        8'h60, 8'h7B, 8'h67, 8'h47, 8'h7A, 8'h5A, 8'h80, 8'hFF
    };

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [7:0]                 s_tdata;
    logic                       s_tlast;
    logic                       m_tvalid;
    logic                       m_tready;
    logic [((VW+7)/8)*8-1:0]    m_tdata;
    logic [2:0]                 m_tuser;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic                       cfg_data;
    int                         mismatches;
    int                         awaiting;

    int                         src_idle;
    int                         rcv_idle;
    logic [7:0]                 chars[$];

    always #2 aclk = ~aclk;

    prefixed_integer_parser #(
        .VALUE_WIDTH(VW)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    parse_checker #(
        .VALUE_WIDTH(VW)
    ) checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    // valid stays high between back-to-back words; it drops only on an idle cycle or in settle
    task automatic push_char(input logic [7:0] c, input logic lst);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            push_char(s[i], i == s.len() - 1);
        end
    endtask

    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (awaiting != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_signed(input logic en);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= en;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] noise_char();
        if ($urandom_range(1)) return 8'($urandom_range(255));
        return ODD_CHARS[$urandom_range(15)];
    endfunction

    function automatic logic [7:0] digit_char(input int unsigned base);
        int unsigned v;
        v = $urandom_range(base - 1);
        if (v < 10) return prsint_pkg::CH_ZERO + 8'(v);
        return ($urandom_range(1) ? prsint_pkg::CH_LOWER_A : prsint_pkg::CH_UPPER_A)
               + 8'(v - 10);
    endfunction

    // mostly well-formed numbers, some with one corrupted char, some pure noise
    task automatic build_number();
        int          kind;
        int          ndig;
        int unsigned base;
        logic [7:0]  pfx;
        chars.delete();
        kind = $urandom_range(99);
        if (kind >= 85) begin
            ndig = $urandom_range(1, 4);
            repeat (ndig) chars.push_back(noise_char());
            return;
        end
        if ($urandom_range(3) == 0) chars.push_back(prsint_pkg::CH_MINUS);
        base = 10;
        pfx  = 8'h00;
        case ($urandom_range(4))
            2: begin base = 16; pfx = prsint_pkg::CH_LOWER_X; end
            3: begin base = 2;  pfx = prsint_pkg::CH_LOWER_B; end
            4: begin base = 8;  pfx = prsint_pkg::CH_LOWER_O; end
            default: ;
        endcase
        if (pfx != 8'h00) begin
            chars.push_back(prsint_pkg::CH_ZERO);
            chars.push_back($urandom_range(1) ? pfx : pfx - prsint_pkg::CASE_OFFSET);
        end
        // long strings exercise the 64-bit wrap
        ndig = ($urandom_range(4) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
        if (ndig == 0 && chars.size() == 0) ndig = 1;
        repeat (ndig) chars.push_back(digit_char(base));
        if (kind >= 70) chars[$urandom_range(chars.size() - 1)] = noise_char();
    endtask

    initial begin
        int sent;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        s_tlast   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        src_idle  = 8;
        rcv_idle  = 51;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_text("0");
        send_text("-");
        send_text("0x");
        send_text("-0B");
        send_text("0o7");
        send_text("9Z");
        send_text("--");
        send_text("0b2");
        push_char(8'h00, 1'b1);
        push_char(8'hFF, 1'b1);
        // sign taken, then signed mode turned off in mid-string
        push_char(prsint_pkg::CH_MINUS, 1'b0);
        settle();
        write_signed(1'b0);
        push_char(prsint_pkg::CH_ZERO + 8'd5, 1'b1);
        send_text("-");

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin src_idle = 8;  rcv_idle = 51; end
                1: begin src_idle = 51; rcv_idle = 8;  end
                default: begin src_idle = 0; rcv_idle = 0; end
            endcase
            settle();
            write_signed(ph != 1);
            sent = 0;
            while (sent < PHASE_CHARS) begin
                build_number();
                foreach (chars[i]) push_char(chars[i], i == chars.size() - 1);
                sent += chars.size();
            end
        end
        settle();

        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
